FILE: hdl/hstd_pkg.sv
package hstd_pkg;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_BAD = 2'd1;
   localparam logic [1:0] STATUS_OVF = 2'd2;

   localparam logic [5:0] DIGIT_ZERO = 6'd48;
   localparam logic [5:0] DIGIT_NONE = 6'd0;

   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_0     = 8'h30;
   localparam logic [7:0] CHR_9     = 8'h39;
   localparam logic [7:0] CHR_UC_A  = 8'h41;
   localparam logic [7:0] CHR_UC_F  = 8'h46;
   localparam logic [7:0] CHR_LC_A  = 8'h61;
   localparam logic [7:0] CHR_LC_F  = 8'h66;
   localparam logic [7:0] CHR_UC_X  = 8'h58;
   localparam logic [7:0] CHR_LC_X  = 8'h78;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_LATER  = 2'd2;

   typedef struct packed {
      logic       acc;
      logic [3:0] nib;
      logic       last;
      logic       bad;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ACC,
      BK_FIN,
      BK_EMIT
   } back_state_type;

endpackage

FILE: hdl/hstd_front.sv
module hstd_front
   import hstd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] hex_char,
   input  logic       final_char,
   output logic       push,
   output cmd_type    cmd
);

   logic [1:0] pos_ff, pos_in;
   logic       fz_ff, fz_in;
   logic       ended_ff, ended_in;
   logic       bad_ff, bad_in;

   logic       is_dec, is_uc, is_lc, is_hex, is_prefix;
   logic [3:0] nib;
   logic       take_nib, bad_now;

   always_comb begin
      is_dec = (hex_char >= CHR_0) && (hex_char <= CHR_9);
      is_uc  = (hex_char >= CHR_UC_A) && (hex_char <= CHR_UC_F);
      is_lc  = (hex_char >= CHR_LC_A) && (hex_char <= CHR_LC_F);
      is_hex = is_dec || is_uc || is_lc;
      if (is_dec) begin
         nib = 4'(hex_char - CHR_0);
      end else if (is_uc) begin
         nib = 4'(hex_char - CHR_UC_A + 8'd10);
      end else begin
         nib = 4'(hex_char - CHR_LC_A + 8'd10);
      end
      is_prefix = (pos_ff == POS_SECOND) && fz_ff &&
                  ((hex_char == CHR_LC_X) || (hex_char == CHR_UC_X));
   end

   always_comb begin
      pos_in   = pos_ff;
      fz_in    = fz_ff;
      ended_in = ended_ff;
      bad_in   = bad_ff;
      take_nib = 1'b0;
      bad_now  = 1'b0;
      if (accept) begin
         if (pos_ff != POS_LATER) begin
            pos_in = pos_ff + 2'd1;
         end
         if (!ended_ff) begin
            if (hex_char == CHR_NUL) begin
               ended_in = 1'b1;
            end else if (!is_prefix) begin
               if (is_hex) begin
                  take_nib = 1'b1;
                  if ((pos_ff == POS_FIRST) && (hex_char == CHR_0)) begin
                     fz_in = 1'b1;
                  end
               end else begin
                  bad_now  = 1'b1;
                  bad_in   = 1'b1;
                  ended_in = 1'b1;
               end
            end
         end
         if (final_char) begin
            pos_in   = POS_FIRST;
            fz_in    = 1'b0;
            ended_in = 1'b0;
            bad_in   = 1'b0;
         end
      end
   end

   always_comb begin
      push     = accept && (take_nib || final_char);
      cmd.acc  = take_nib;
      cmd.nib  = nib;
      cmd.last = final_char;
      cmd.bad  = bad_ff || bad_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_FIRST;
         fz_ff    <= 1'b0;
         ended_ff <= 1'b0;
         bad_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         fz_ff    <= fz_in;
         ended_ff <= ended_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

FILE: hdl/hstd_queue.sv
module hstd_queue
   import hstd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    full,
   output logic    empty
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   always_comb begin
      full      = (cnt_ff == 2'd2);
      empty     = (cnt_ff == 2'd0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      pop_data  = slot_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: hdl/hstd_back.sv
module hstd_back
   import hstd_pkg::*;
#(
   parameter int DEC_DIGITS = 40
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_ready,
   input  cmd_type    cmd,
   output logic       cmd_take,
   output logic       rsp_strobe,
   output logic [5:0] rsp_digit_char,
   output logic [1:0] rsp_status,
   output logic       rsp_run_end
);

   localparam int IDX_W = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(DEC_DIGITS - 1);
   localparam logic [IDX_W-1:0] FIRST = '0;

   back_state_type state_ff, state_in;

   logic [3:0]            mem [DEC_DIGITS];
   logic [DEC_DIGITS-1:0] valid_ff;
   logic [3:0]            rdata_ff;
   logic                  rvalid_ff;

   logic             iss_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pidx_ff;
   logic [4:0]       carry_ff;
   logic             fin_ff;
   logic             bad_ff;
   logic             ovf_ff;
   logic             lead_ff;

   logic [3:0]  dig;
   logic [7:0]  val;
   logic [15:0] prod;
   logic [4:0]  quo;
   logic [3:0]  rem;
   logic        rd_en, wr_en, last_done, emit_now, err_now, clear_now;

   always_comb begin
      dig  = rvalid_ff ? rdata_ff : 4'd0;
      val  = {dig, 4'd0} + {3'd0, carry_ff};
      prod = {8'd0, val} * 16'd205;
      quo  = prod[15:11];
      rem  = 4'(val - 8'(quo) * 8'd10);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_ready) begin
               state_in = cmd.acc ? BK_ACC : BK_FIN;
            end
         end
         BK_ACC: begin
            if (pend_ff && (pidx_ff == LAST)) begin
               state_in = fin_ff ? BK_FIN : BK_IDLE;
            end
         end
         BK_FIN: begin
            state_in = (bad_ff || ovf_ff) ? BK_IDLE : BK_EMIT;
         end
         BK_EMIT: begin
            if (pend_ff && (pidx_ff == FIRST)) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_take       = 1'b0;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      last_done      = 1'b0;
      emit_now       = 1'b0;
      err_now        = 1'b0;
      clear_now      = 1'b0;
      rsp_strobe     = 1'b0;
      rsp_digit_char = DIGIT_NONE;
      rsp_status     = STATUS_OK;
      rsp_run_end    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            cmd_take = cmd_ready;
         end
         BK_ACC: begin
            rd_en     = iss_ff;
            wr_en     = pend_ff;
            last_done = pend_ff && (pidx_ff == LAST);
         end
         BK_FIN: begin
            if (bad_ff || ovf_ff) begin
               err_now     = 1'b1;
               clear_now   = 1'b1;
               rsp_strobe  = 1'b1;
               rsp_status  = bad_ff ? STATUS_BAD : STATUS_OVF;
               rsp_run_end = 1'b1;
            end
         end
         BK_EMIT: begin
            rd_en = iss_ff;
            if (pend_ff && ((dig != 4'd0) || !lead_ff || (pidx_ff == FIRST))) begin
               emit_now       = 1'b1;
               rsp_strobe     = 1'b1;
               rsp_digit_char = DIGIT_ZERO + {2'd0, dig};
               rsp_run_end    = (pidx_ff == FIRST);
            end
            clear_now = pend_ff && (pidx_ff == FIRST);
         end
         default: begin
            cmd_take = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff  <= mem[idx_ff];
         rvalid_ff <= valid_ff[idx_ff];
      end
      if (wr_en) begin
         mem[pidx_ff] <= rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= '0;
         iss_ff   <= 1'b0;
         idx_ff   <= FIRST;
         pend_ff  <= 1'b0;
         pidx_ff  <= FIRST;
         carry_ff <= 5'd0;
         fin_ff   <= 1'b0;
         bad_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         lead_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         pend_ff  <= rd_en;
         if (rd_en) begin
            pidx_ff <= idx_ff;
         end
         if (cmd_take) begin
            iss_ff   <= cmd.acc;
            idx_ff   <= FIRST;
            carry_ff <= {1'b0, cmd.nib};
            fin_ff   <= cmd.last;
            bad_ff   <= cmd.bad;
         end else if (state_ff == BK_ACC) begin
            if (rd_en) begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == LAST) begin
                  iss_ff <= 1'b0;
               end
            end
         end else if (state_ff == BK_FIN) begin
            iss_ff  <= !err_now;
            idx_ff  <= LAST;
            lead_ff <= 1'b1;
         end else if (state_ff == BK_EMIT) begin
            if (rd_en) begin
               idx_ff <= idx_ff - 1'b1;
               if (idx_ff == FIRST) begin
                  iss_ff <= 1'b0;
               end
            end
         end
         if (wr_en) begin
            valid_ff[pidx_ff] <= 1'b1;
            carry_ff          <= quo;
         end
         if (last_done && (quo != 5'd0)) begin
            ovf_ff <= 1'b1;
         end
         if (emit_now) begin
            lead_ff <= 1'b0;
         end
         if (clear_now) begin
            valid_ff <= '0;
            ovf_ff   <= 1'b0;
         end
      end
   end

endmodule

FILE: hdl/hex_string_to_decimal_string.sv
// channel  direction  handshake                 payload
// request  in         start & !busy             req_hex_char, req_final_char
// result   out        rsp_strobe, one cycle     rsp_digit_char, rsp_status, rsp_run_end
//
// A hex digit is taken from the queue, then goes through a pipelined x16 / divide-by-ten
// pass over the digit memory, one digit a cycle, and a drain step writes the last digit.
// A final character adds a read-out of the digit memory (on an error, only the error
// result), plus a take step when it carries no hex digit.
// busy rises only while the two-entry command queue is full.
// Synchronous reset clears the per-digit valid bits and the error flags; results cannot be stalled.
module hex_string_to_decimal_string
   import hstd_pkg::*;
#(
   parameter int DEC_DIGITS = 40
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_hex_char,
   input  logic       req_final_char,
   output logic       rsp_strobe,
   output logic [5:0] rsp_digit_char,
   output logic [1:0] rsp_status,
   output logic       rsp_run_end
);

   logic    accept;
   logic    push;
   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    q_full, q_empty;
   logic    cmd_take;

   assign busy   = q_full;
   assign accept = start && !q_full;

   hstd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .hex_char   (req_hex_char),
      .final_char (req_final_char),
      .push       (push),
      .cmd        (push_cmd)
   );

   hstd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (cmd_take),
      .pop_data  (pop_cmd),
      .full      (q_full),
      .empty     (q_empty)
   );

   hstd_back #(
      .DEC_DIGITS (DEC_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_ready      (!q_empty),
      .cmd            (pop_cmd),
      .cmd_take       (cmd_take),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_status     (rsp_status),
      .rsp_run_end    (rsp_run_end)
   );

   a_err_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |->
         (rsp_run_end && (rsp_digit_char == DIGIT_NONE)))
      else $error("error result not a lone run end");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_status == STATUS_OK) || (rsp_status == STATUS_BAD) ||
                      (rsp_status == STATUS_OVF)))
      else $error("bad status code");

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> !q_empty)
      else $error("command taken from empty queue");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (q_full && !cmd_take) |=> q_full)
      else $error("queue drained without a take");

endmodule
